FILE: rtl/frs_pkg.sv
// ----------------------------------------------------------------------------
// frs_pkg
// types and constants shared by the flash record scanner
// ----------------------------------------------------------------------------
`default_nettype none

package frs_pkg;

  localparam int unsigned ADDR_W  = 25;
  localparam int unsigned LEN_W   = 16;
  localparam int unsigned SUM_W   = 16;

  localparam logic [ADDR_W-1:0] LIMIT_RESET = 25'd32768;
  localparam logic [LEN_W-1:0]  LEN_ERASED  = 16'hFFFF;
  localparam logic [LEN_W-1:0]  LEN_END     = 16'h0000;

  // request codes
  localparam logic REQ_START = 1'b0;
  localparam logic REQ_BYTE  = 1'b1;

  // header byte positions
  localparam logic [1:0] HDR_LEN_LO = 2'd0;
  localparam logic [1:0] HDR_LEN_HI = 2'd1;
  localparam logic [1:0] HDR_SUM_LO = 2'd2;
  localparam logic [1:0] HDR_SUM_HI = 2'd3;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_HEADER  = 2'd1,
    PH_PAYLOAD = 2'd2,
    PH_SKIP    = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    STOP_END_MARK = 2'd0,
    STOP_ERASED   = 2'd1,
    STOP_BAD_SUM  = 2'd2,
    STOP_REGION   = 2'd3
  } stop_reason_t;

  typedef struct packed {
    logic         byte_valid;
    logic [7:0]   data;
    logic         last;
    logic         good;
    logic         stopped;
    stop_reason_t reason;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/flash_record_scanner.sv
// ----------------------------------------------------------------------------
// flash_record_scanner
// walks length/checksum framed records in flash and streams their payloads
// ----------------------------------------------------------------------------
// A start item (in_req_type 0) opens a scan at address zero; every following
// byte item (in_req_type 1) is the next flash byte in address order. Each
// record is a 4-byte header (little-endian 16-bit length, then little-endian
// 16-bit byte sum) and its payload. Payloads shorter than MAX_PAYLOAD come out
// one item per byte, the last one flagged with the checksum result; payloads of
// MAX_PAYLOAD or more are skipped with no output. A zero length (end marker), an
// erased length of 0xFFFF, a checksum mismatch, or reaching cfg_region_limit at
// a record boundary ends the scan with out_stopped set. The header decode, the
// 16-bit running sum and the 25-bit address compare sit between the input port
// and a single output register, so one item is taken every cycle as long as
// out_stall lets that register drain. Bytes that arrive while no scan is
// running give no result. The region limit may be written over the cfg port
// while the block is idle; cfg_ready is always high. No clearing pass is
// needed after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module flash_record_scanner
  import frs_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD = 1024
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,

  // input item channel
  input  wire logic                  in_valid,
  output      logic                  in_stall,
  input  wire logic                  in_req_type,
  input  wire logic [7:0]            in_flash_byte,

  // result item channel
  output      logic                  out_valid,
  input  wire logic                  out_stall,
  output      logic                  out_byte_valid,
  output      logic [7:0]            out_byte,
  output      logic                  out_message_last,
  output      logic                  out_message_good,
  output      logic                  out_stopped,
  output      logic [1:0]            out_stop_reason,

  // region limit write port
  input  wire logic                  cfg_valid,
  output      logic                  cfg_ready,
  input  wire logic [ADDR_W-1:0]     cfg_region_limit
);

  // records at or above this length are skipped
  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PAYLOAD);

  // scan state
  phase_t            phase_r,        phase_nxt;
  logic [1:0]        hdr_idx_r,      hdr_idx_nxt;
  logic [LEN_W-1:0]  rec_len_r,      rec_len_nxt;
  logic [SUM_W-1:0]  stored_sum_r,   stored_sum_nxt;
  logic [SUM_W-1:0]  run_sum_r,      run_sum_nxt;
  logic [LEN_W-1:0]  bytes_left_r,   bytes_left_nxt;
  logic [ADDR_W-1:0] addr_r,         addr_nxt;
  logic [ADDR_W-1:0] limit_r,        limit_nxt;

  // output register
  logic              out_valid_r,    out_valid_nxt;
  result_t           res_r,          res_nxt;

  // per-item helpers
  logic              in_acc;
  logic              out_acc;
  logic              res_fire;
  result_t           res;
  logic [ADDR_W-1:0] addr_inc;
  logic [LEN_W-1:0]  left_dec;
  logic [SUM_W-1:0]  sum_add;
  logic [SUM_W-1:0]  hdr_sum;
  logic              at_limit;

  // the output register frees up in the same cycle it is taken
  assign in_stall  = out_valid_r & out_stall;
  assign in_acc    = in_valid & ~in_stall;
  assign out_acc   = out_valid_r & ~out_stall;
  assign cfg_ready = 1'b1;

  assign addr_inc = addr_r + ADDR_W'(1);
  assign left_dec = (bytes_left_r == '0) ? '0 : bytes_left_r - LEN_W'(1);
  assign sum_add  = run_sum_r + SUM_W'(in_flash_byte);
  assign hdr_sum  = {in_flash_byte, stored_sum_r[7:0]};
  // boundary test uses the address after this byte
  assign at_limit = addr_inc >= limit_r;

  // item decode
  always_comb begin
    phase_nxt      = phase_r;
    hdr_idx_nxt    = hdr_idx_r;
    rec_len_nxt    = rec_len_r;
    stored_sum_nxt = stored_sum_r;
    run_sum_nxt    = run_sum_r;
    bytes_left_nxt = bytes_left_r;
    addr_nxt       = addr_r;
    res            = '0;
    res_fire       = 1'b0;

    if (in_acc) begin
      if (in_req_type == REQ_START) begin
        // restart at address zero, stop at once on an empty region
        addr_nxt       = '0;
        rec_len_nxt    = '0;
        stored_sum_nxt = '0;
        run_sum_nxt    = '0;
        bytes_left_nxt = '0;
        hdr_idx_nxt    = HDR_LEN_LO;
        if (limit_r == '0) begin
          phase_nxt   = PH_IDLE;
          res.stopped = 1'b1;
          res.reason  = STOP_REGION;
          res_fire    = 1'b1;
        end else begin
          phase_nxt = PH_HEADER;
        end
      end else begin
        case (phase_r)
          PH_HEADER: begin
            addr_nxt = addr_inc;
            case (hdr_idx_r)
              HDR_LEN_LO: begin
                rec_len_nxt = {8'h00, in_flash_byte};
                hdr_idx_nxt = HDR_LEN_HI;
              end
              HDR_LEN_HI: begin
                rec_len_nxt = {in_flash_byte, rec_len_r[7:0]};
                hdr_idx_nxt = HDR_SUM_LO;
              end
              HDR_SUM_LO: begin
                stored_sum_nxt = {8'h00, in_flash_byte};
                hdr_idx_nxt    = HDR_SUM_HI;
              end
              default: begin
                // last header byte: classify the record
                stored_sum_nxt = hdr_sum;
                hdr_idx_nxt    = HDR_LEN_LO;
                if (rec_len_r == LEN_END) begin
                  phase_nxt   = PH_IDLE;
                  res.stopped = 1'b1;
                  res.reason  = STOP_END_MARK;
                  res_fire    = 1'b1;
                end else if (rec_len_r == LEN_ERASED) begin
                  phase_nxt   = PH_IDLE;
                  res.stopped = 1'b1;
                  res.reason  = STOP_ERASED;
                  res_fire    = 1'b1;
                end else begin
                  bytes_left_nxt = rec_len_r;
                  run_sum_nxt    = '0;
                  phase_nxt      = (rec_len_r < MAX_LEN) ? PH_PAYLOAD : PH_SKIP;
                end
              end
            endcase
          end

          PH_PAYLOAD: begin
            addr_nxt       = addr_inc;
            bytes_left_nxt = left_dec;
            run_sum_nxt    = sum_add;
            res.byte_valid = 1'b1;
            res.data       = in_flash_byte;
            res_fire       = 1'b1;
            if (left_dec == '0) begin
              res.last = 1'b1;
              if (sum_add != stored_sum_r) begin
                phase_nxt   = PH_IDLE;
                res.stopped = 1'b1;
                res.reason  = STOP_BAD_SUM;
              end else begin
                res.good    = 1'b1;
                hdr_idx_nxt = HDR_LEN_LO;
                if (at_limit) begin
                  phase_nxt   = PH_IDLE;
                  res.stopped = 1'b1;
                  res.reason  = STOP_REGION;
                end else begin
                  phase_nxt = PH_HEADER;
                end
              end
            end
          end

          PH_SKIP: begin
            addr_nxt       = addr_inc;
            bytes_left_nxt = left_dec;
            if (left_dec == '0) begin
              hdr_idx_nxt = HDR_LEN_LO;
              if (at_limit) begin
                phase_nxt   = PH_IDLE;
                res.stopped = 1'b1;
                res.reason  = STOP_REGION;
                res_fire    = 1'b1;
              end else begin
                phase_nxt = PH_HEADER;
              end
            end
          end

          default: begin
            // idle: stray bytes are dropped
          end
        endcase
      end
    end
  end

  // output register and config next values
  always_comb begin
    limit_nxt = limit_r;
    if (cfg_valid && cfg_ready) begin
      limit_nxt = cfg_region_limit;
    end

    out_valid_nxt = out_valid_r;
    res_nxt       = res_r;
    if (res_fire) begin
      out_valid_nxt = 1'b1;
      res_nxt       = res;
    end else if (out_acc) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      hdr_idx_r    <= HDR_LEN_LO;
      rec_len_r    <= '0;
      stored_sum_r <= '0;
      run_sum_r    <= '0;
      bytes_left_r <= '0;
      addr_r       <= '0;
      limit_r      <= LIMIT_RESET;
      out_valid_r  <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      hdr_idx_r    <= hdr_idx_nxt;
      rec_len_r    <= rec_len_nxt;
      stored_sum_r <= stored_sum_nxt;
      run_sum_r    <= run_sum_nxt;
      bytes_left_r <= bytes_left_nxt;
      addr_r       <= addr_nxt;
      limit_r      <= limit_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_byte_valid   = res_r.byte_valid;
  assign out_byte         = res_r.data;
  assign out_message_last = res_r.last;
  assign out_message_good = res_r.good;
  assign out_stopped      = res_r.stopped;
  assign out_stop_reason  = res_r.reason;

endmodule

`default_nettype wire

FILE: tb/sv/flash_record_scanner_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// flash_record_scanner_tb
// self-checking bench for the flash record scanner
// ----------------------------------------------------------------------------
// A queue of flash items (start requests and flash bytes) feeds a clocked
// driver. Every accepted item goes through a local model of the scanner, which
// queues the result it should cause. A clocked monitor checks each accepted
// result against the oldest queued one, field by field. Directed items come
// first, then a few small region limit cases, then random scans under several
// region limits. Both channels idle at random with three idle mixes.
// ----------------------------------------------------------------------------

module flash_record_scanner_tb;
  import frs_pkg::*;

  localparam int unsigned MAX_PAYLOAD  = 1024;
  localparam int unsigned ITEM_TARGET  = 1450;
  localparam int unsigned RAND_PHASES  = 9;
  localparam int unsigned SETTLE_TICKS = 8;
  localparam int unsigned CYCLE_LIMIT  = 500000;

  typedef struct packed {
    logic       req;
    logic [7:0] data;
  } flash_item_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // item input channel
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              in_req_type = REQ_START;
  logic [7:0]        in_flash_byte = 8'h00;

  // result channel
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              out_byte_valid;
  logic [7:0]        out_byte;
  logic              out_message_last;
  logic              out_message_good;
  logic              out_stopped;
  logic [1:0]        out_stop_reason;

  // region limit write port
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [ADDR_W-1:0] cfg_region_limit = LIMIT_RESET;

  // stimulus and scoreboard
  flash_item_t flash_stream[$];
  result_t     scan_results[$];
  int unsigned items_queued = 0;
  int unsigned items_taken = 0;
  int unsigned items_counted = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;

  // scanner model state, reset values
  phase_t            scan_phase = PH_IDLE;
  logic [1:0]        hdr_pos = HDR_LEN_LO;
  logic [LEN_W-1:0]  rec_len = '0;
  logic [SUM_W-1:0]  stored_sum = '0;
  logic [SUM_W-1:0]  run_sum = '0;
  logic [LEN_W-1:0]  bytes_left = '0;
  logic [ADDR_W-1:0] scan_addr = '0;
  logic [ADDR_W-1:0] region_lim = LIMIT_RESET;

  flash_record_scanner #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_req_type      (in_req_type),
    .in_flash_byte    (in_flash_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_byte_valid   (out_byte_valid),
    .out_byte         (out_byte),
    .out_message_last (out_message_last),
    .out_message_good (out_message_good),
    .out_stopped      (out_stopped),
    .out_stop_reason  (out_stop_reason),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_region_limit (cfg_region_limit)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // hard stop in case the block hangs
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // scanner model
  // ---------------------------------------------------------------------------

  // record boundary: the region limit is only looked at here
  function automatic logic at_record_boundary();
    hdr_pos = HDR_LEN_LO;
    if (scan_addr >= region_lim) begin
      scan_phase = PH_IDLE;
      return 1'b1;
    end
    scan_phase = PH_HEADER;
    return 1'b0;
  endfunction

  // advance the model by one accepted item, queue the result it causes
  task automatic predict_scan_step(input logic req, input logic [7:0] b);
    result_t r;
    logic    emit;
    r = '0;
    emit = 1'b0;
    if (req == REQ_START) begin
      // restart at address zero, even mid-scan
      scan_addr  = '0;
      rec_len    = '0;
      stored_sum = '0;
      run_sum    = '0;
      bytes_left = '0;
      if (at_record_boundary()) begin
        r.stopped = 1'b1;
        r.reason  = STOP_REGION;
        emit      = 1'b1;
      end
    end else if (scan_phase != PH_IDLE) begin
      scan_addr = scan_addr + 1'b1;
      if (scan_phase == PH_HEADER) begin
        case (hdr_pos)
          HDR_LEN_LO: rec_len = {8'h00, b};
          HDR_LEN_HI: rec_len[15:8] = b;
          HDR_SUM_LO: stored_sum = {8'h00, b};
          default:    stored_sum[15:8] = b;
        endcase
        if (hdr_pos != HDR_SUM_HI) begin
          hdr_pos = hdr_pos + 2'd1;
        end else begin
          hdr_pos = HDR_LEN_LO;
          if (rec_len == LEN_END) begin
            scan_phase = PH_IDLE;
            r.stopped  = 1'b1;
            r.reason   = STOP_END_MARK;
            emit       = 1'b1;
          end else if (rec_len == LEN_ERASED) begin
            scan_phase = PH_IDLE;
            r.stopped  = 1'b1;
            r.reason   = STOP_ERASED;
            emit       = 1'b1;
          end else begin
            bytes_left = rec_len;
            run_sum    = '0;
            scan_phase = (rec_len < MAX_PAYLOAD) ? PH_PAYLOAD : PH_SKIP;
          end
        end
      end else begin
        if (bytes_left != 0) bytes_left = bytes_left - 1'b1;
        if (scan_phase == PH_PAYLOAD) begin
          run_sum      = run_sum + b;
          r.byte_valid = 1'b1;
          r.data       = b;
          emit         = 1'b1;
          if (bytes_left == 0) begin
            r.last = 1'b1;
            if (run_sum != stored_sum) begin
              scan_phase = PH_IDLE;
              r.stopped  = 1'b1;
              r.reason   = STOP_BAD_SUM;
            end else begin
              r.good = 1'b1;
              if (at_record_boundary()) begin
                r.stopped = 1'b1;
                r.reason  = STOP_REGION;
              end
            end
          end
        end else if (bytes_left == 0 && at_record_boundary()) begin
          // oversized record skipped right up to the limit
          r.stopped = 1'b1;
          r.reason  = STOP_REGION;
          emit      = 1'b1;
        end
      end
    end
    if (emit) scan_results.push_back(r);
  endtask

  // ---------------------------------------------------------------------------
  // driver: one item in flight, fed from flash_stream
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    flash_item_t nxt;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        predict_scan_step(in_req_type, in_flash_byte);
        items_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (flash_stream.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          nxt = flash_stream.pop_front();
          in_valid      <= 1'b1;
          in_req_type   <= nxt.req;
          in_flash_byte <= nxt.data;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: random stall, check each accepted result
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst_n) begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
      if (out_valid && !out_stall) begin
        if (scan_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual byte 0x%0h stopped %0b",
                   $time, out_byte, out_stopped);
          mismatches++;
        end else begin
          want = scan_results.pop_front();
          check_field("byte_valid", want.byte_valid, out_byte_valid);
          check_field("out_byte", want.data, out_byte);
          check_field("message_last", want.last, out_message_last);
          check_field("message_good", want.good, out_message_good);
          check_field("stopped", want.stopped, out_stopped);
          check_field("stop_reason", want.reason, out_stop_reason);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic queue_item(input logic req, input logic [7:0] b, input bit counted);
    flash_item_t it;
    it.req  = req;
    it.data = b;
    flash_stream.push_back(it);
    items_queued++;
    if (counted) items_counted++;
  endtask

  // header plus payload; a bad record carries a corrupted stored sum
  task automatic add_record(input int unsigned len, input bit good);
    logic [7:0]  body[$];
    logic [7:0]  b;
    logic [15:0] sum;
    logic [15:0] hdr_sum;
    sum = '0;
    for (int unsigned i = 0; i < len; i++) begin
      b = 8'($urandom);
      body.push_back(b);
      sum = sum + b;
    end
    hdr_sum = good ? sum : sum ^ 16'($urandom_range(1, 65535));
    queue_item(REQ_BYTE, len[7:0], 1);
    queue_item(REQ_BYTE, len[15:8], 1);
    queue_item(REQ_BYTE, hdr_sum[7:0], 1);
    queue_item(REQ_BYTE, hdr_sum[15:8], 1);
    foreach (body[i]) queue_item(REQ_BYTE, body[i], 1);
  endtask

  // one random scan: start, some records, then some way of ending
  task automatic add_scan();
    int unsigned nrec;
    int unsigned pick;
    int unsigned len;
    queue_item(REQ_START, 8'($urandom), 1);
    nrec = $urandom_range(0, 6);
    repeat (nrec) begin
      pick = $urandom_range(99);
      if (pick < 12) len = $urandom_range(41, 200);
      else           len = $urandom_range(1, 40);
      add_record(len, $urandom_range(99) < 85);
    end
    pick = $urandom_range(99);
    if (pick < 30) begin
      // end marker
      queue_item(REQ_BYTE, 8'h00, 1);
      queue_item(REQ_BYTE, 8'h00, 1);
      queue_item(REQ_BYTE, 8'($urandom), 1);
      queue_item(REQ_BYTE, 8'($urandom), 1);
    end else if (pick < 50) begin
      // erased flash
      queue_item(REQ_BYTE, 8'hFF, 1);
      queue_item(REQ_BYTE, 8'hFF, 1);
      queue_item(REQ_BYTE, 8'($urandom), 1);
      queue_item(REQ_BYTE, 8'($urandom), 1);
    end else if (pick < 65) begin
      // header cut short, next start interrupts it
      repeat ($urandom_range(1, 3)) queue_item(REQ_BYTE, 8'($urandom), 1);
    end else if (pick < 80) begin
      // noise: mostly bytes, the rest start requests
      repeat ($urandom_range(1, 6)) queue_item($urandom_range(99) < 85, 8'($urandom), 0);
    end
  endtask

  // block is quiet: all items taken, all results in, pipeline flushed
  task automatic wait_quiet();
    while (items_taken != items_queued || scan_results.size() != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  task automatic write_region_limit(input logic [ADDR_W-1:0] value);
    @(posedge clk);
    cfg_valid        <= 1'b1;
    cfg_region_limit <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    region_lim = value;
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [ADDR_W-1:0] lim;
    int unsigned       quota;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // sender idles less than the receiver first
    tx_idle_pct = 32;
    rx_idle_pct = 57;

    // directed, default region limit
    queue_item(REQ_BYTE, 8'hA5, 0);          // byte before any scan, ignored
    queue_item(REQ_START, 8'h00, 1);
    queue_item(REQ_BYTE, 8'h02, 1);          // length 2, sum 0x00ff
    queue_item(REQ_BYTE, 8'h00, 1);
    queue_item(REQ_BYTE, 8'hFF, 1);
    queue_item(REQ_BYTE, 8'h00, 1);
    queue_item(REQ_BYTE, 8'h00, 1);          // payload extremes
    queue_item(REQ_BYTE, 8'hFF, 1);
    queue_item(REQ_BYTE, 8'h01, 1);          // length 1 with wrong sum
    queue_item(REQ_BYTE, 8'h00, 1);
    queue_item(REQ_BYTE, 8'h34, 1);
    queue_item(REQ_BYTE, 8'h12, 1);
    queue_item(REQ_BYTE, 8'h77, 1);          // checksum mismatch stop
    queue_item(REQ_START, 8'hFF, 1);
    queue_item(REQ_BYTE, 8'h05, 1);          // half a header
    queue_item(REQ_BYTE, 8'h00, 1);
    queue_item(REQ_START, 8'h5A, 1);         // restart mid-scan
    queue_item(REQ_BYTE, 8'h00, 1);          // end marker
    queue_item(REQ_BYTE, 8'h00, 1);
    queue_item(REQ_BYTE, 8'hAB, 1);
    queue_item(REQ_BYTE, 8'hCD, 1);
    queue_item(REQ_START, 8'h00, 1);
    queue_item(REQ_BYTE, 8'hFF, 1);          // erased flash
    queue_item(REQ_BYTE, 8'hFF, 1);
    queue_item(REQ_BYTE, 8'h00, 1);
    queue_item(REQ_BYTE, 8'h00, 1);
    wait_quiet();

    // zero limit: every start stops at once
    write_region_limit('0);
    queue_item(REQ_START, 8'($urandom), 1);
    queue_item(REQ_BYTE, 8'($urandom), 0);
    queue_item(REQ_START, 8'($urandom), 1);
    wait_quiet();

    // record crosses the limit, good last byte also ends the scan
    write_region_limit(ADDR_W'(7));
    queue_item(REQ_START, 8'($urandom), 1);
    add_record(5, 1'b1);
    queue_item(REQ_BYTE, 8'($urandom), 0);
    wait_quiet();

    // skipped record ends exactly on the limit
    write_region_limit(ADDR_W'(4 + MAX_PAYLOAD));
    queue_item(REQ_START, 8'($urandom), 1);
    add_record(MAX_PAYLOAD, 1'b1);
    wait_quiet();

    // random scans under a rotation of limits
    quota = (ITEM_TARGET > items_counted) ? (ITEM_TARGET - items_counted) / RAND_PHASES : 1;
    for (int unsigned p = 0; p < RAND_PHASES; p++) begin
      case (p % 4)
        0:       lim = ADDR_W'(25'd16777216);
        1:       lim = ADDR_W'($urandom_range(10, 300));
        2:       lim = ADDR_W'($urandom_range(300, 3000));
        default: lim = ADDR_W'($urandom_range(0, 12));
      endcase
      write_region_limit(lim);
      if (p < 3) begin
        tx_idle_pct = 32;
        rx_idle_pct = 57;
      end else if (p < 6) begin
        tx_idle_pct = 57;
        rx_idle_pct = 32;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      quota = items_counted + quota;
      while (items_counted < quota) add_scan();
      quota = (ITEM_TARGET > items_counted) ?
              (ITEM_TARGET - items_counted) / (RAND_PHASES - p) : 1;
      wait_quiet();
    end

    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
